// ----- src/assert_macros.svh -----
// assertion helper macros shared by the header line lexer modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled during reset
`define HHL_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// implication check, disabled during reset
`define HHL_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/hhl_pkg.sv -----
// shared types, codes and character class functions for the header line lexer
// no dependencies
package hhl_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_EOL   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] COOKIE_LEN = 4'd10;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_NAME     = 3'd1,
        ST_NO_NAME      = 3'd2,
        ST_BAD_VALUE    = 3'd3,
        ST_FOLD_NO_LINE = 3'd4,
        ST_WS_OVERFLOW  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_NAME  = 3'd1,
        PH_OWS   = 3'd2,
        PH_VALUE = 3'd3,
        PH_ERROR = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        FL_IDLE  = 2'd0,
        FL_SPACE = 2'd1,
        FL_LAST  = 2'd2
    } flush_state_t;

    typedef enum logic [3:0] {
        ACT_NONE   = 4'd0,
        ACT_NAME   = 4'd1,
        ACT_COLON  = 4'd2,
        ACT_FOLD   = 4'd3,
        ACT_VALUE  = 4'd4,
        ACT_FLUSH  = 4'd5,
        ACT_HOLD   = 4'd6,
        ACT_FAIL   = 4'd7,
        ACT_STATUS = 4'd8,
        ACT_CLEAR  = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        CMD_NAME   = 2'd0,
        CMD_SPACE  = 2'd1,
        CMD_VALUE  = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_t;

    // status words carry {3'b0, status, set_cookie, folded} in data
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
        logic       last;
    } qentry_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic tok_char(input logic [7:0] c);
        logic r;
        r = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h30 && c <= 8'h39) ||
            c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 || c == 8'h26 ||
            c == 8'h27 || c == 8'h2A || c == 8'h2B || c == 8'h2D || c == 8'h2E ||
            c == 8'h5E || c == 8'h5F || c == 8'h60 || c == 8'h7C || c == 8'h7E;
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_visible(input logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h7E) || c >= 8'h80;
    endfunction

    function automatic logic [7:0] cookie_char(input logic [3:0] pos);
        logic [7:0] r;
        unique case (pos)
            4'd0:    r = 8'h73;
            4'd1:    r = 8'h65;
            4'd2:    r = 8'h74;
            4'd3:    r = 8'h2D;
            4'd4:    r = 8'h63;
            4'd5:    r = 8'h6F;
            4'd6:    r = 8'h6F;
            4'd7:    r = 8'h6B;
            4'd8:    r = 8'h69;
            4'd9:    r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- src/hhl_fifo.sv -----
// short word queue between the lexer front and back
// depends on hhl_pkg and assert_macros.svh
`include "assert_macros.svh"

module hhl_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  hhl_pkg::qentry_t wr_entry,
    output logic            full,
    input  logic            pop,
    output hhl_pkg::qentry_t rd_entry,
    output logic            empty
);

    hhl_pkg::qentry_t entries [hhl_pkg::Q_DEPTH];

    logic [hhl_pkg::Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [hhl_pkg::Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [hhl_pkg::Q_AW:0]   cnt_reg, cnt_next;

    assign full     = cnt_reg == (hhl_pkg::Q_AW + 1)'(hhl_pkg::Q_DEPTH);
    assign empty    = cnt_reg == '0;
    assign rd_entry = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + hhl_pkg::Q_AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + hhl_pkg::Q_AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (hhl_pkg::Q_AW + 1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (hhl_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= wr_entry;
        end
    end

    `HHL_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
    `HHL_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, !empty, "pop from empty queue")
    `HHL_ASSERT(a_count_bound, clk, rst_n, cnt_reg <= (hhl_pkg::Q_AW + 1)'(hhl_pkg::Q_DEPTH), "queue count out of range")

endmodule

// ----- src/hhl_front.sv -----
// lexer front: takes input words, tracks line state, holds trailing whitespace
// and flushes it into the queue; depends on hhl_pkg and assert_macros.svh
`include "assert_macros.svh"

module hhl_front
#(
    parameter int WS_HOLD_DEPTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       op,
    input  logic [7:0]       data_byte,
    input  logic             q_full,
    output logic             q_push,
    output hhl_pkg::qentry_t q_entry
);

    localparam int AW = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
    localparam int CW = $clog2(WS_HOLD_DEPTH + 1);

    logic                  allow_fold_reg, allow_fold_next;
    hhl_pkg::phase_t       phase_reg, phase_next;
    logic [CW-1:0]         hold_cnt_reg, hold_cnt_next;
    logic [3:0]            ck_pos_reg, ck_pos_next;
    logic                  ck_miss_reg, ck_miss_next;
    logic                  earlier_reg, earlier_next;
    hhl_pkg::status_t      err_reg, err_next;
    logic                  folded_reg, folded_next;
    hhl_pkg::flush_state_t fl_state_reg, fl_state_next;
    logic [CW-1:0]         fl_cnt_reg, fl_cnt_next;
    logic [CW-1:0]         fl_ptr_reg, fl_ptr_next;
    logic [7:0]            pend_reg, pend_next;
    logic                  ws_rd_reg;

    logic                  ws_mem [WS_HOLD_DEPTH];
    logic                  mem_we, mem_wd, rd_en;
    logic [AW-1:0]         mem_wa, mem_ra;

    logic                  accept;
    hhl_pkg::action_t      act;
    hhl_pkg::status_t      fail_code;
    hhl_pkg::status_t      eol_status;
    logic                  eol_cookie;
    logic [CW-1:0]         ptr_inc;
    logic [7:0]            lc_byte;

    assign in_ready = (fl_state_reg == hhl_pkg::FL_IDLE) && !q_full;
    assign accept   = in_valid && in_ready;
    assign ptr_inc  = fl_ptr_reg + CW'(1);
    assign lc_byte  = hhl_pkg::to_lower(data_byte);

    // classify the word against the line phase
    always_comb
    begin
        act       = hhl_pkg::ACT_NONE;
        fail_code = hhl_pkg::ST_OK;
        if (op == hhl_pkg::OP_BYTE)
        begin
            unique case (phase_reg)
                hhl_pkg::PH_START:
                begin
                    if (hhl_pkg::tok_char(data_byte))
                    begin
                        act = hhl_pkg::ACT_NAME;
                    end
                    else if (hhl_pkg::is_blank(data_byte) && allow_fold_reg)
                    begin
                        act = hhl_pkg::ACT_FOLD;
                    end
                    else
                    begin
                        act       = hhl_pkg::ACT_FAIL;
                        fail_code = hhl_pkg::ST_NO_NAME;
                    end
                end
                hhl_pkg::PH_NAME:
                begin
                    if (hhl_pkg::tok_char(data_byte))
                    begin
                        act = hhl_pkg::ACT_NAME;
                    end
                    else if (data_byte == hhl_pkg::CH_COLON)
                    begin
                        act = hhl_pkg::ACT_COLON;
                    end
                    else
                    begin
                        act       = hhl_pkg::ACT_FAIL;
                        fail_code = hhl_pkg::ST_BAD_NAME;
                    end
                end
                hhl_pkg::PH_OWS, hhl_pkg::PH_VALUE:
                begin
                    if (hhl_pkg::is_visible(data_byte))
                    begin
                        act = (hold_cnt_reg == '0) ? hhl_pkg::ACT_VALUE : hhl_pkg::ACT_FLUSH;
                    end
                    else if (hhl_pkg::is_blank(data_byte))
                    begin
                        if (phase_reg == hhl_pkg::PH_OWS)
                        begin
                            act = hhl_pkg::ACT_NONE;
                        end
                        else if (hold_cnt_reg >= CW'(WS_HOLD_DEPTH))
                        begin
                            act       = hhl_pkg::ACT_FAIL;
                            fail_code = hhl_pkg::ST_WS_OVERFLOW;
                        end
                        else
                        begin
                            act = hhl_pkg::ACT_HOLD;
                        end
                    end
                    else
                    begin
                        act       = hhl_pkg::ACT_FAIL;
                        fail_code = hhl_pkg::ST_BAD_VALUE;
                    end
                end
                default:
                begin
                    act = hhl_pkg::ACT_NONE;
                end
            endcase
        end
        else if (op == hhl_pkg::OP_EOL)
        begin
            act = hhl_pkg::ACT_STATUS;
        end
        else if (op == hhl_pkg::OP_CLEAR)
        begin
            act = hhl_pkg::ACT_CLEAR;
        end

        priority if (phase_reg == hhl_pkg::PH_ERROR)
        begin
            eol_status = err_reg;
        end
        else if (phase_reg == hhl_pkg::PH_START)
        begin
            eol_status = hhl_pkg::ST_NO_NAME;
        end
        else if (phase_reg == hhl_pkg::PH_NAME)
        begin
            eol_status = hhl_pkg::ST_BAD_NAME;
        end
        else if (folded_reg && !earlier_reg)
        begin
            eol_status = hhl_pkg::ST_FOLD_NO_LINE;
        end
        else
        begin
            eol_status = hhl_pkg::ST_OK;
        end
        eol_cookie = !folded_reg && !ck_miss_reg && (ck_pos_reg == hhl_pkg::COOKIE_LEN);
    end

    // next state
    always_comb
    begin
        allow_fold_next = cfg_we ? cfg_data : allow_fold_reg;
        phase_next      = phase_reg;
        hold_cnt_next   = hold_cnt_reg;
        ck_pos_next     = ck_pos_reg;
        ck_miss_next    = ck_miss_reg;
        earlier_next    = earlier_reg;
        err_next        = err_reg;
        folded_next     = folded_reg;
        fl_state_next   = fl_state_reg;
        fl_cnt_next     = fl_cnt_reg;
        fl_ptr_next     = fl_ptr_reg;
        pend_next       = pend_reg;
        unique case (fl_state_reg)
            hhl_pkg::FL_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        hhl_pkg::ACT_NAME:
                        begin
                            phase_next = hhl_pkg::PH_NAME;
                            if (ck_pos_reg < hhl_pkg::COOKIE_LEN &&
                                lc_byte == hhl_pkg::cookie_char(ck_pos_reg))
                            begin
                                ck_pos_next = ck_pos_reg + 4'd1;
                            end
                            else
                            begin
                                ck_miss_next = 1'b1;
                            end
                        end
                        hhl_pkg::ACT_COLON:
                        begin
                            phase_next = hhl_pkg::PH_OWS;
                        end
                        hhl_pkg::ACT_FOLD:
                        begin
                            phase_next  = hhl_pkg::PH_OWS;
                            folded_next = 1'b1;
                        end
                        hhl_pkg::ACT_VALUE:
                        begin
                            phase_next = hhl_pkg::PH_VALUE;
                        end
                        hhl_pkg::ACT_FLUSH:
                        begin
                            phase_next    = hhl_pkg::PH_VALUE;
                            fl_state_next = hhl_pkg::FL_SPACE;
                            fl_cnt_next   = hold_cnt_reg;
                            fl_ptr_next   = '0;
                            hold_cnt_next = '0;
                            pend_next     = data_byte;
                        end
                        hhl_pkg::ACT_HOLD:
                        begin
                            hold_cnt_next = hold_cnt_reg + CW'(1);
                        end
                        hhl_pkg::ACT_FAIL:
                        begin
                            phase_next = hhl_pkg::PH_ERROR;
                            err_next   = fail_code;
                        end
                        hhl_pkg::ACT_STATUS:
                        begin
                            phase_next    = hhl_pkg::PH_START;
                            hold_cnt_next = '0;
                            ck_pos_next   = '0;
                            ck_miss_next  = 1'b0;
                            err_next      = hhl_pkg::ST_OK;
                            folded_next   = 1'b0;
                            if (eol_status == hhl_pkg::ST_OK)
                            begin
                                earlier_next = 1'b1;
                            end
                        end
                        hhl_pkg::ACT_CLEAR:
                        begin
                            earlier_next = 1'b0;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            hhl_pkg::FL_SPACE:
            begin
                if (!q_full)
                begin
                    fl_ptr_next = ptr_inc;
                    if (ptr_inc == fl_cnt_reg)
                    begin
                        fl_state_next = hhl_pkg::FL_LAST;
                    end
                end
            end
            hhl_pkg::FL_LAST:
            begin
                if (!q_full)
                begin
                    fl_state_next = hhl_pkg::FL_IDLE;
                end
            end
            default:
            begin
                fl_state_next = hhl_pkg::FL_IDLE;
            end
        endcase
    end

    // outputs: queue words and hold memory access
    always_comb
    begin
        q_push        = 1'b0;
        q_entry.cmd   = hhl_pkg::CMD_VALUE;
        q_entry.data  = data_byte;
        q_entry.last  = 1'b1;
        mem_we        = 1'b0;
        mem_wa        = hold_cnt_reg[AW-1:0];
        mem_wd        = data_byte == hhl_pkg::CH_TAB;
        rd_en         = 1'b0;
        mem_ra        = '0;
        unique case (fl_state_reg)
            hhl_pkg::FL_IDLE:
            begin
                if (accept)
                begin
                    unique case (act)
                        hhl_pkg::ACT_NAME:
                        begin
                            q_push      = 1'b1;
                            q_entry.cmd = hhl_pkg::CMD_NAME;
                        end
                        hhl_pkg::ACT_VALUE:
                        begin
                            q_push = 1'b1;
                        end
                        hhl_pkg::ACT_STATUS:
                        begin
                            q_push       = 1'b1;
                            q_entry.cmd  = hhl_pkg::CMD_STATUS;
                            q_entry.data = {3'b000, eol_status, eol_cookie, folded_reg};
                        end
                        hhl_pkg::ACT_HOLD:
                        begin
                            mem_we = 1'b1;
                        end
                        hhl_pkg::ACT_FLUSH:
                        begin
                            rd_en = 1'b1;
                        end
                        default:
                        begin
                            q_push = 1'b0;
                        end
                    endcase
                end
            end
            hhl_pkg::FL_SPACE:
            begin
                q_push       = !q_full;
                q_entry.cmd  = hhl_pkg::CMD_SPACE;
                q_entry.data = {7'b0000000, ws_rd_reg};
                q_entry.last = 1'b0;
                rd_en        = !q_full && (ptr_inc < fl_cnt_reg);
                mem_ra       = ptr_inc[AW-1:0];
            end
            hhl_pkg::FL_LAST:
            begin
                q_push       = !q_full;
                q_entry.data = pend_reg;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_fold_reg <= 1'b0;
            phase_reg      <= hhl_pkg::PH_START;
            hold_cnt_reg   <= '0;
            ck_pos_reg     <= '0;
            ck_miss_reg    <= 1'b0;
            earlier_reg    <= 1'b0;
            err_reg        <= hhl_pkg::ST_OK;
            folded_reg     <= 1'b0;
            fl_state_reg   <= hhl_pkg::FL_IDLE;
            fl_cnt_reg     <= '0;
            fl_ptr_reg     <= '0;
        end
        else
        begin
            allow_fold_reg <= allow_fold_next;
            phase_reg      <= phase_next;
            hold_cnt_reg   <= hold_cnt_next;
            ck_pos_reg     <= ck_pos_next;
            ck_miss_reg    <= ck_miss_next;
            earlier_reg    <= earlier_next;
            err_reg        <= err_next;
            folded_reg     <= folded_next;
            fl_state_reg   <= fl_state_next;
            fl_cnt_reg     <= fl_cnt_next;
            fl_ptr_reg     <= fl_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    // held whitespace kinds, 1 = tab
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ws_mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            ws_rd_reg <= ws_mem[mem_ra];
        end
    end

    `HHL_ASSERT_IMPL(a_no_accept_in_flush, clk, rst_n,
        fl_state_reg != hhl_pkg::FL_IDLE, !in_ready, "word accepted during flush")
    `HHL_ASSERT(a_hold_bound, clk, rst_n,
        hold_cnt_reg <= CW'(WS_HOLD_DEPTH), "held whitespace count out of range")
    `HHL_ASSERT_IMPL(a_space_only_in_flush, clk, rst_n,
        q_push && q_entry.cmd == hhl_pkg::CMD_SPACE,
        fl_state_reg == hhl_pkg::FL_SPACE, "whitespace word outside flush")

endmodule

// ----- src/hhl_back.sv -----
// lexer back: pops queue words, decodes them into result fields and holds
// them in the output register; depends on hhl_pkg
module hhl_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  hhl_pkg::qentry_t q_entry,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic [2:0]       status,
    output logic             is_set_cookie,
    output logic             is_folded,
    output logic             run_end
);

    logic       valid_reg, valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic [2:0] status_reg, status_next;
    logic       cookie_reg, cookie_next;
    logic       folded_reg, folded_next;
    logic       last_reg, last_next;

    assign q_pop = !q_empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        cookie_next = cookie_reg;
        folded_next = folded_reg;
        last_next   = last_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (q_pop)
        begin
            valid_next  = 1'b1;
            last_next   = q_entry.last;
            status_next = hhl_pkg::ST_OK;
            cookie_next = 1'b0;
            folded_next = 1'b0;
            unique case (q_entry.cmd)
                hhl_pkg::CMD_NAME:
                begin
                    kind_next = hhl_pkg::KIND_NAME;
                    byte_next = hhl_pkg::to_lower(q_entry.data);
                end
                hhl_pkg::CMD_SPACE:
                begin
                    kind_next = hhl_pkg::KIND_VALUE;
                    byte_next = q_entry.data[0] ? hhl_pkg::CH_TAB : hhl_pkg::CH_SPACE;
                end
                hhl_pkg::CMD_VALUE:
                begin
                    kind_next = hhl_pkg::KIND_VALUE;
                    byte_next = q_entry.data;
                end
                hhl_pkg::CMD_STATUS:
                begin
                    kind_next   = hhl_pkg::KIND_STATUS;
                    byte_next   = 8'h00;
                    status_next = q_entry.data[4:2];
                    cookie_next = q_entry.data[1];
                    folded_next = q_entry.data[0];
                end
                default:
                begin
                    kind_next = hhl_pkg::KIND_VALUE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        cookie_reg <= cookie_next;
        folded_reg <= folded_next;
        last_reg   <= last_next;
    end

    assign out_valid     = valid_reg;
    assign kind          = kind_reg;
    assign out_byte      = byte_reg;
    assign status        = status_reg;
    assign is_set_cookie = cookie_reg;
    assign is_folded     = folded_reg;
    assign run_end       = last_reg;

endmodule

// ----- src/http_header_line_lexer.sv -----
// HTTP header line lexer: checks one header line per run of input words and
// emits the lowercased name, the trimmed value and an end-of-line status.
// Input channel in_valid/in_ready carries op and data_byte. op byte feeds one
// line byte, op end-of-line closes the line, op clear drops the earlier-line
// flag. Output channel out_valid/out_ready carries kind, out_byte, status,
// is_set_cookie, is_folded; run_end marks the last word caused by an input.
// cfg_we/cfg_data write allow_fold; the user must do so only while the
// block is idle, which the block itself does not enforce. Throughput: one
// input word per cycle while in_ready is high. A visible value byte that
// follows held spaces or tabs starts the front's flush sequencer: it reads
// the hold memory, emits one whitespace word per cycle while the queue has
// room, then the byte itself, and holds in_ready low until it is done.
// Reset clears allow_fold, the earlier-line flag and the line state; the hold
// memory needs no clearing. When the receiver stalls, the four-word queue
// fills and in_ready drops until space frees up.
module http_header_line_lexer
#(
    parameter int WS_HOLD_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       is_set_cookie,
    output logic       is_folded,
    output logic       run_end
);

    logic             q_push, q_full, q_pop, q_empty;
    hhl_pkg::qentry_t wr_entry, rd_entry;

    hhl_front #(
        .WS_HOLD_DEPTH (WS_HOLD_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .data_byte (data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (wr_entry)
    );

    hhl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (rd_entry),
        .empty    (q_empty)
    );

    hhl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_entry       (rd_entry),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .out_byte      (out_byte),
        .status        (status),
        .is_set_cookie (is_set_cookie),
        .is_folded     (is_folded),
        .run_end       (run_end)
    );

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for http_header_line_lexer, a short table of directed
// header lines, then random well-formed and broken lines under both fold settings
// depends on hhl_pkg and the http_header_line_lexer rtl
module tb_top;

    localparam int HOLD_DEPTH = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam logic [79:0] COOKIE_NAME = "set-cookie";

    localparam int LINE_PLAIN = 0;
    localparam int LINE_COOKIE = 1;
    localparam int LINE_NEAR_COOKIE = 2;
    localparam int LINE_FOLD = 3;
    localparam int LINE_JUNK = 4;
    localparam int LINE_BLANK_RUN = 5;

    typedef struct packed {
        logic [1:0]       op;
        logic [7:0]       data;
        logic             pin;
        hhl_pkg::status_t st;
        logic             ck;
        logic             fo;
    } lex_item_t;

    typedef struct packed {
        logic             fold;
        logic [1:0]       op;
        logic [7:0]       data;
        logic             pin;
        hhl_pkg::status_t st;
        logic             ck;
        logic             fo;
    } dir_row_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [2:0] st;
        logic       ck;
        logic       fo;
        logic       last;
    } lex_word_t;

    localparam int DIR_ROWS = 31;
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_NO_NAME,      1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h41, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h3A, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h20, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h80, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h09, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'hFF, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h20, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h7E, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h00, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h21, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_BAD_NAME,     1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h30, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_BAD_NAME,     1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h78, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h3A, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h7F, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_BAD_VALUE,    1'b0, 1'b0},
        '{1'b0, OP_NOP,            8'hA5, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_BYTE,  8'h20, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b0, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_NO_NAME,      1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_CLEAR, 8'h00, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_BYTE,  8'h09, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_FOLD_NO_LINE, 1'b0, 1'b1},
        '{1'b1, hhl_pkg::OP_BYTE,  8'h6B, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_BYTE,  8'h3A, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_BYTE,  8'h20, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_BYTE,  8'h77, 1'b0, hhl_pkg::ST_OK,           1'b0, 1'b0},
        '{1'b1, hhl_pkg::OP_EOL,   8'h00, 1'b1, hhl_pkg::ST_OK,           1'b0, 1'b1}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       is_set_cookie;
    logic       is_folded;
    logic       run_end;

    lex_item_t line_items [$];
    lex_word_t expected_words [$];
    lex_item_t cur_item;
    bit        in_fire = 1'b0;
    bit        noise_on = 1'b0;
    int        items_queued = 0;
    int        words_seen = 0;
    int        mismatches = 0;
    int        cycle_count = 0;

    // lexer model state
    bit               fold_en = 1'b0;
    hhl_pkg::phase_t  line_phase = hhl_pkg::PH_START;
    bit               held_tab [HOLD_DEPTH];
    int               held_count = 0;
    int               cookie_pos = 0;
    bit               cookie_bad = 1'b0;
    bit               earlier_ok = 1'b0;
    hhl_pkg::status_t line_err = hhl_pkg::ST_OK;
    bit               line_folded = 1'b0;

    http_header_line_lexer #(.WS_HOLD_DEPTH(HOLD_DEPTH)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .data_byte(data_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind(kind),
        .out_byte(out_byte),
        .status(status),
        .is_set_cookie(is_set_cookie),
        .is_folded(is_folded),
        .run_end(run_end)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic bit tok_byte(input logic [7:0] b);
        case (b)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", 8'h60, "|", "~":
                return 1'b1;
            default:
                return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                       (b >= "a" && b <= "z");
        endcase
    endfunction

    function automatic bit is_ws(input logic [7:0] b);
        return b == hhl_pkg::CH_SPACE || b == hhl_pkg::CH_TAB;
    endfunction

    function automatic bit is_vis(input logic [7:0] b);
        return (b >= 8'h21 && b <= 8'h7E) || b[7];
    endfunction

    task add_word(input logic [1:0] k, input logic [7:0] c, input hhl_pkg::status_t s,
                  input logic ck, input logic fo);
        lex_word_t w;
        w.kind = k;
        w.ch = c;
        w.st = s;
        w.ck = ck;
        w.fo = fo;
        w.last = 1'b0;
        expected_words.insert(expected_words.size(), w);
    endtask

    task line_fail(input hhl_pkg::status_t code);
        line_err = code;
        line_phase = hhl_pkg::PH_ERROR;
    endtask

    task emit_name(input logic [7:0] b);
        logic [7:0] lc;
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (cookie_pos < hhl_pkg::COOKIE_LEN && lc == COOKIE_NAME[79 - 8 * cookie_pos -: 8])
            cookie_pos++;
        else
            cookie_bad = 1'b1;
        add_word(hhl_pkg::KIND_NAME, lc, hhl_pkg::ST_OK, 1'b0, 1'b0);
    endtask

    task emit_value(input logic [7:0] b);
        int i;
        if (is_vis(b))
        begin
            for (i = 0; i < held_count; i++)
                add_word(hhl_pkg::KIND_VALUE,
                         held_tab[i] ? hhl_pkg::CH_TAB : hhl_pkg::CH_SPACE,
                         hhl_pkg::ST_OK, 1'b0, 1'b0);
            held_count = 0;
            add_word(hhl_pkg::KIND_VALUE, b, hhl_pkg::ST_OK, 1'b0, 1'b0);
            line_phase = hhl_pkg::PH_VALUE;
        end
        else if (is_ws(b))
        begin
            if (held_count >= HOLD_DEPTH)
                line_fail(hhl_pkg::ST_WS_OVERFLOW);
            else
            begin
                held_tab[held_count] = (b == hhl_pkg::CH_TAB);
                held_count++;
            end
        end
        else
            line_fail(hhl_pkg::ST_BAD_VALUE);
    endtask

    task lex_predict(input lex_item_t it);
        int words_prior;
        hhl_pkg::status_t st;
        bit ck;
        lex_word_t w;
        words_prior = expected_words.size();
        if (it.op == hhl_pkg::OP_BYTE)
        begin
            case (line_phase)
                hhl_pkg::PH_START:
                begin
                    if (tok_byte(it.data))
                    begin
                        emit_name(it.data);
                        line_phase = hhl_pkg::PH_NAME;
                    end
                    else if (is_ws(it.data) && fold_en)
                    begin
                        line_folded = 1'b1;
                        line_phase = hhl_pkg::PH_OWS;
                    end
                    else
                        line_fail(hhl_pkg::ST_NO_NAME);
                end
                hhl_pkg::PH_NAME:
                begin
                    if (tok_byte(it.data))
                        emit_name(it.data);
                    else if (it.data == hhl_pkg::CH_COLON)
                        line_phase = hhl_pkg::PH_OWS;
                    else
                        line_fail(hhl_pkg::ST_BAD_NAME);
                end
                hhl_pkg::PH_OWS:
                begin
                    if (!is_ws(it.data))
                        emit_value(it.data);
                end
                hhl_pkg::PH_VALUE:
                    emit_value(it.data);
                default:
                    ;
            endcase
        end
        else if (it.op == hhl_pkg::OP_EOL)
        begin
            if (line_phase == hhl_pkg::PH_ERROR)
                st = line_err;
            else if (line_phase == hhl_pkg::PH_START)
                st = hhl_pkg::ST_NO_NAME;
            else if (line_phase == hhl_pkg::PH_NAME)
                st = hhl_pkg::ST_BAD_NAME;
            else if (line_folded && !earlier_ok)
                st = hhl_pkg::ST_FOLD_NO_LINE;
            else
                st = hhl_pkg::ST_OK;
            ck = !line_folded && !cookie_bad && cookie_pos == hhl_pkg::COOKIE_LEN;
            if (st == hhl_pkg::ST_OK)
                earlier_ok = 1'b1;
            if (it.pin)
                add_word(hhl_pkg::KIND_STATUS, 8'h00, it.st, it.ck, it.fo);
            else
                add_word(hhl_pkg::KIND_STATUS, 8'h00, st, ck, line_folded);
            line_phase = hhl_pkg::PH_START;
            held_count = 0;
            cookie_pos = 0;
            cookie_bad = 1'b0;
            line_err = hhl_pkg::ST_OK;
            line_folded = 1'b0;
        end
        else if (it.op == hhl_pkg::OP_CLEAR)
            earlier_ok = 1'b0;
        if (expected_words.size() > words_prior)
        begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.insert(expected_words.size(), w);
        end
    endtask

    task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("mismatch at word %0d: %s got %0d exp %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    task check_word;
        lex_word_t w;
        words_seen++;
        if (expected_words.size() == 0)
            report_mismatch("word with nothing pending, kind", 8'(kind), 8'h00);
        else
        begin
            w = expected_words.pop_front();
            if (kind !== w.kind)
                report_mismatch("kind", 8'(kind), 8'(w.kind));
            if (out_byte !== w.ch)
                report_mismatch("out_byte", out_byte, w.ch);
            if (status !== w.st)
                report_mismatch("status", 8'(status), 8'(w.st));
            if (is_set_cookie !== w.ck)
                report_mismatch("is_set_cookie", 8'(is_set_cookie), 8'(w.ck));
            if (is_folded !== w.fo)
                report_mismatch("is_folded", 8'(is_folded), 8'(w.fo));
            if (run_end !== w.last)
                report_mismatch("run_end", 8'(run_end), 8'(w.last));
        end
    endtask

    always @(posedge clk)
    begin
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
            lex_predict(cur_item);
        if (rst_n && out_valid && out_ready)
            check_word;
    end

    // sender: bursts of words with random gaps
    initial
    begin : sender
        int burst_left;
        int gap_left;
        in_valid = 1'b0;
        op = hhl_pkg::OP_BYTE;
        data_byte = 8'h00;
        burst_left = $urandom_range(1, 24);
        gap_left = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!in_valid || in_fire)
            begin
                if (gap_left > 0)
                begin
                    in_valid = 1'b0;
                    gap_left--;
                end
                else if (line_items.size() > 0)
                begin
                    cur_item = line_items.pop_front();
                    op = cur_item.op;
                    data_byte = cur_item.data;
                    in_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(1, 6);
                    end
                end
                else
                    in_valid = 1'b0;
            end
        end
    end

    // receiver: stall pattern per window, plus a long hold-off now and then
    initial
    begin : receiver
        int mode;
        int win;
        int hold_left;
        int next_hold;
        out_ready = 1'b0;
        mode = 0;
        win = 0;
        hold_left = 0;
        next_hold = 60;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && words_seen >= next_hold)
            begin
                hold_left = 48;
                next_hold = next_hold + 170;
            end
            if (win == 0)
            begin
                mode = $urandom_range(0, 2);
                win = $urandom_range(16, 48);
            end
            win--;
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else if (mode == 0)
                out_ready = 1'b1;
            else if (mode == 1)
                out_ready = !out_ready;
            else
                out_ready = ($urandom_range(0, 3) != 0);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [7:0] rand_tchar();
        logic [7:0] b;
        do
            b = 8'($urandom_range(33, 126));
        while (!tok_byte(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_vis();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (!is_vis(b));
        return b;
    endfunction

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? hhl_pkg::CH_TAB : hhl_pkg::CH_SPACE;
    endfunction

    task add_item(input logic [1:0] o, input logic [7:0] b);
        lex_item_t it;
        it = '0;
        if (noise_on && $urandom_range(0, 19) == 0)
        begin
            it.op = $urandom_range(0, 1) ? hhl_pkg::OP_CLEAR : OP_NOP;
            it.data = 8'($urandom);
            line_items.insert(line_items.size(), it);
        end
        it.op = o;
        it.data = b;
        line_items.insert(line_items.size(), it);
        items_queued++;
    endtask

    task add_ows;
        int n;
        int i;
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            add_item(hhl_pkg::OP_BYTE, rand_blank());
    endtask

    task add_value;
        int n;
        int i;
        int r;
        logic [7:0] b;
        n = $urandom_range(0, 10);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 15);
            if (r < 3)
                b = rand_blank();
            else if (r == 3 && $urandom_range(0, 3) == 0)
            begin
                b = 8'($urandom_range(0, 31));
                if (b == hhl_pkg::CH_TAB)
                    b = 8'h7F;
            end
            else
                b = rand_vis();
            add_item(hhl_pkg::OP_BYTE, b);
        end
        add_ows;
    endtask

    task gen_line(input int shape, input int run_len);
        int n;
        int i;
        logic [7:0] b;
        case (shape)
            LINE_COOKIE, LINE_NEAR_COOKIE:
            begin
                n = (shape == LINE_NEAR_COOKIE) ? $urandom_range(7, 11) : 10;
                for (i = 0; i < n; i++)
                begin
                    b = (i < 10) ? COOKIE_NAME[79 - 8 * i -: 8] : 8'h78;
                    if (b >= "a" && $urandom_range(0, 1))
                        b = b - 8'd32;
                    add_item(hhl_pkg::OP_BYTE, b);
                end
                add_item(hhl_pkg::OP_BYTE, hhl_pkg::CH_COLON);
                add_ows;
                add_value;
            end
            LINE_FOLD:
            begin
                add_item(hhl_pkg::OP_BYTE, rand_blank());
                add_ows;
                add_value;
            end
            LINE_JUNK:
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    add_item(hhl_pkg::OP_BYTE, 8'($urandom));
            end
            LINE_BLANK_RUN:
            begin
                add_item(hhl_pkg::OP_BYTE, rand_tchar());
                add_item(hhl_pkg::OP_BYTE, hhl_pkg::CH_COLON);
                add_item(hhl_pkg::OP_BYTE, rand_vis());
                for (i = 0; i < run_len; i++)
                    add_item(hhl_pkg::OP_BYTE, rand_blank());
                add_item(hhl_pkg::OP_BYTE, rand_vis());
            end
            default:
            begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    add_item(hhl_pkg::OP_BYTE, rand_tchar());
                add_item(hhl_pkg::OP_BYTE, hhl_pkg::CH_COLON);
                add_ows;
                add_value;
            end
        endcase
        add_item(hhl_pkg::OP_EOL, 8'h00);
    endtask

    function automatic int pick_shape();
        int r;
        r = $urandom_range(0, 15);
        if (r < 7 || r == 15)
            return LINE_PLAIN;
        else if (r < 8)
            return LINE_COOKIE;
        else if (r < 9)
            return LINE_NEAR_COOKIE;
        else if (r < 12)
            return LINE_FOLD;
        else if (r < 14)
            return LINE_JUNK;
        return LINE_BLANK_RUN;
    endfunction

    task fill_random(input int target);
        int first;
        first = items_queued;
        while (items_queued - first < target)
            gen_line(pick_shape(), $urandom_range(2, 12));
    endtask

    task wait_idle;
        while (line_items.size() != 0 || in_valid || expected_words.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task set_fold(input bit v);
        wait_idle;
        cfg_data = v;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        fold_en = v;
    endtask

    initial
    begin : main
        int i;
        lex_item_t it;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (i == 0 || dir_rows[i].fold != fold_en)
                set_fold(dir_rows[i].fold);
            it.op = dir_rows[i].op;
            it.data = dir_rows[i].data;
            it.pin = dir_rows[i].pin;
            it.st = dir_rows[i].st;
            it.ck = dir_rows[i].ck;
            it.fo = dir_rows[i].fo;
            line_items.insert(line_items.size(), it);
        end

        noise_on = 1'b1;
        set_fold(1'b1);
        gen_line(LINE_COOKIE, 0);
        gen_line(LINE_BLANK_RUN, HOLD_DEPTH);
        gen_line(LINE_BLANK_RUN, HOLD_DEPTH + 1);
        fill_random(6);
        set_fold(1'b0);
        fill_random(5);
        set_fold(1'b1);
        fill_random(5);
        wait_idle;

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
